// ===== hw/rtl/gregorian_calendar_date_unit_defines.svh =====
// Assertion macros shared by the calendar date unit.
`ifndef GREGORIAN_CALENDAR_DATE_UNIT_DEFINES_SVH
`define GREGORIAN_CALENDAR_DATE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GCDU_ASSERT_IMP(name, c, r, a, b) \
  name: assert property (@(posedge c) disable iff (r) (a) |-> (b)) \
    else $error("gcdu same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define GCDU_ASSERT_NXT(name, c, r, a, b) \
  name: assert property (@(posedge c) disable iff (r) (a) |=> (b)) \
    else $error("gcdu next-cycle check failed");

`endif

// ===== hw/rtl/gcdu_pkg.sv =====
package gcdu_pkg;

  localparam int YEAR_W     = 17;
  localparam int DAYS_W     = 26;
  localparam int SECS_W     = 40;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 80;

  typedef logic signed [YEAR_W-1:0] year_t;
  typedef logic [YEAR_W-1:0]        dividend_t;
  typedef logic [8:0]               divisor_t;
  typedef logic [3:0]               month_t;
  typedef logic [4:0]               mday_t;
  typedef logic [8:0]               yday_t;
  typedef logic signed [DAYS_W-1:0] days_t;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_NEXT    = 2'd1,
    ACT_PREV    = 2'd2,
    ACT_COMPARE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_BOUND   = 2'd2
  } status_t;

  localparam logic [1:0] ORD_LATER   = 2'b01;
  localparam logic [1:0] ORD_EQUAL   = 2'b00;
  localparam logic [1:0] ORD_EARLIER = 2'b11;

  // Years are biased by a multiple of 400 so that floor division works on
  // a non-negative dividend.
  localparam int YEAR_BIAS      = 32800;
  localparam int EPOCH_YEAR     = 1970;
  localparam int LEAPS_TO_EPOCH = (EPOCH_YEAR - 1) / 4 - (EPOCH_YEAR - 1) / 100
                                  + (EPOCH_YEAR - 1) / 400;
  localparam int DAY_BASE       = -(YEAR_BIAS / 4) + YEAR_BIAS / 100 - YEAR_BIAS / 400
                                  - LEAPS_TO_EPOCH - 365 * EPOCH_YEAR - 1;

  localparam dividend_t DIVIDEND_BIAS = dividend_t'(YEAR_BIAS - 1);
  localparam divisor_t  DIV_400       = 9'd400;
  localparam divisor_t  DIV_100       = 9'd100;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_NOP,
    OP_DIV_GIVEN,
    OP_VALIDATE,
    OP_STEP,
    OP_DIV_Y400,
    OP_TAKE_Q400,
    OP_DIV_Y100,
    OP_SUM_YEARS,
    OP_SUM_CENT,
    OP_SUM_REST,
    OP_SCALE,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_load;
    logic div_busy;
    logic out_free;
  } dp_status_t;

  function automatic yday_t days_before(input month_t m);
    yday_t d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Returns zero for a month outside 1..12.
  function automatic mday_t month_len(input month_t m, input logic leap);
    mday_t n;
    case (m)
      4'd2:                                   n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:                n = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      default:                                n = 5'd0;
    endcase
    return n;
  endfunction

  // The argument is (year - 1) mod 400.
  function automatic logic leap_from_rem(input divisor_t r);
    divisor_t ym;
    ym = (r == 9'd399) ? 9'd0 : r + 9'd1;
    return (ym[1:0] == 2'b00) && (ym != 9'd100) && (ym != 9'd200) && (ym != 9'd300);
  endfunction

endpackage

// ===== hw/rtl/gcdu_div.sv =====
module gcdu_div
  import gcdu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  dividend_t dividend,
  input  divisor_t  divisor,
  output dividend_t quot,
  output divisor_t  rem,
  output logic      busy
);

  localparam int                 RECIP_W     = 28;
  localparam int                 RECIP_SHIFT = 17;
  localparam logic [RECIP_W-1:0] RECIP_25    = 28'd5243;
  localparam logic [1:0]         PASS_QUOT   = 2'd2;
  localparam logic [1:0]         PASS_REM    = 2'd1;

  logic [1:0]         count;
  divisor_t           dsor;
  dividend_t          num;
  dividend_t          quot_r;
  divisor_t           rem_r;
  logic [14:0]        scaled;
  logic [RECIP_W-1:0] recip;
  dividend_t          back;

  // Both divisors are 25 times a power of two. The power is shifted out first,
  // and the division by 25 uses a reciprocal that is exact for a 15-bit value.
  assign scaled = (dsor == DIV_400) ? 15'(num >> 4) : 15'(num >> 2);
  assign recip  = RECIP_W'(scaled) * RECIP_25;
  assign back   = quot_r * dividend_t'(dsor);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= PASS_QUOT;
    end else if (count != '0) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsor <= divisor;
      num  <= dividend;
    end else if (count == PASS_QUOT) begin
      quot_r <= dividend_t'(recip[RECIP_W-1:RECIP_SHIFT]);
    end else if (count == PASS_REM) begin
      rem_r <= divisor_t'(num - back);
    end
  end

  assign quot = quot_r;
  assign rem  = rem_r;
  assign busy = count != '0;

endmodule

// ===== hw/rtl/gcdu_datapath.sv =====
module gcdu_datapath
  import gcdu_pkg::*;
#(
  parameter int MIN_YEAR = -9999,
  parameter int MAX_YEAR = 9999
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  dp_cmd_t               cmd,
  output dp_status_t            status
);

  localparam year_t MIN_Y = year_t'(MIN_YEAR);
  localparam year_t MAX_Y = year_t'(MAX_YEAR);
  localparam days_t DAYS_PER_YEAR = days_t'(365);
  localparam days_t DAY_BASE_D = days_t'(DAY_BASE);
  localparam logic signed [43:0] SECS_PER_DAY = 44'sd86400;

  action_t   act;
  year_t     g_year;
  month_t    g_month;
  mday_t     g_day;
  year_t     year;
  month_t    month;
  mday_t     day;
  logic      leap_r;
  logic [7:0] q400;
  days_t     acc;
  logic [SECS_W-1:0] secs;
  logic [1:0] order;
  status_t   stat;
  logic [OUT_DATA_W-1:0] out_data;
  logic      out_valid;

  logic      div_start;
  dividend_t div_dividend;
  divisor_t  div_divisor;
  dividend_t div_quot;
  divisor_t  div_rem;
  logic      div_busy;

  dividend_t year_biased;
  dividend_t given_biased;
  yday_t     ordinal;
  logic      g_leap;
  logic      g_ok;
  mday_t     cur_len;
  mday_t     prev_len;
  logic signed [43:0] prod;
  logic      emit;

  assign year_biased  = dividend_t'(year) + DIVIDEND_BIAS;
  assign given_biased = dividend_t'(g_year) + DIVIDEND_BIAS;

  assign div_start = (cmd.op == OP_DIV_GIVEN) || (cmd.op == OP_DIV_Y400) ||
                     (cmd.op == OP_DIV_Y100);
  assign div_dividend = (cmd.op == OP_DIV_GIVEN) ? given_biased : year_biased;
  assign div_divisor  = (cmd.op == OP_DIV_Y100) ? DIV_100 : DIV_400;

  gcdu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quot     (div_quot),
    .rem      (div_rem),
    .busy     (div_busy)
  );

  assign g_leap = leap_from_rem(div_rem);
  assign g_ok   = (g_month >= 4'd1) && (g_month <= 4'd12) &&
                  (g_year >= MIN_Y) && (g_year <= MAX_Y) &&
                  (g_day != 5'd0) && (g_day <= month_len(g_month, g_leap));

  assign cur_len  = month_len(month, leap_r);
  assign prev_len = month_len(month - 4'd1, leap_r);
  assign ordinal  = days_before(month) + yday_t'(day) +
                    yday_t'((month > 4'd2) && leap_r);
  assign prod     = 44'(acc) * SECS_PER_DAY;
  assign emit     = (cmd.op == OP_EMIT) && status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      year   <= year_t'(EPOCH_YEAR);
      month  <= 4'd1;
      day    <= 5'd1;
      leap_r <= 1'b0;
    end else begin
      case (cmd.op)
        OP_IDLE: begin
          if (s_tvalid) begin
            act     <= action_t'(s_tuser);
            g_year  <= year_t'($signed(s_tdata[14:0]));
            g_month <= s_tdata[18:15];
            g_day   <= s_tdata[23:19];
            order   <= ORD_EQUAL;
            stat    <= ST_OK;
          end
        end
        OP_VALIDATE: begin
          if (g_ok) begin
            year  <= g_year;
            month <= g_month;
            day   <= g_day;
          end else begin
            stat <= ST_INVALID;
          end
        end
        OP_STEP: begin
          case (act)
            ACT_NEXT: begin
              if (day == cur_len) begin
                if (month == 4'd12) begin
                  if (year >= MAX_Y) begin
                    stat <= ST_BOUND;
                  end else begin
                    year  <= year + year_t'(1);
                    month <= 4'd1;
                    day   <= 5'd1;
                  end
                end else begin
                  month <= month + 4'd1;
                  day   <= 5'd1;
                end
              end else begin
                day <= day + 5'd1;
              end
            end
            ACT_PREV: begin
              if (day > 5'd1) begin
                day <= day - 5'd1;
              end else if (month == 4'd1) begin
                if (year <= MIN_Y) begin
                  stat <= ST_BOUND;
                end else begin
                  year  <= year - year_t'(1);
                  month <= 4'd12;
                  day   <= 5'd31;
                end
              end else begin
                month <= month - 4'd1;
                day   <= prev_len;
              end
            end
            ACT_COMPARE: begin
              if (year != g_year) begin
                order <= (year > g_year) ? ORD_LATER : ORD_EARLIER;
              end else if (month != g_month) begin
                order <= (month > g_month) ? ORD_LATER : ORD_EARLIER;
              end else if (day != g_day) begin
                order <= (day > g_day) ? ORD_LATER : ORD_EARLIER;
              end else begin
                order <= ORD_EQUAL;
              end
            end
            default: begin
            end
          endcase
        end
        OP_TAKE_Q400: begin
          q400   <= div_quot[7:0];
          leap_r <= leap_from_rem(div_rem);
        end
        OP_SUM_YEARS: acc <= days_t'(days_t'(year) * DAYS_PER_YEAR);
        OP_SUM_CENT:  acc <= acc + days_t'(q400) - days_t'(div_quot[9:0]);
        OP_SUM_REST: begin
          acc <= acc + days_t'(year_biased[YEAR_W-1:2]) + days_t'(ordinal) + DAY_BASE_D;
        end
        OP_SCALE: secs <= prod[SECS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= {2'b00, stat, order, secs, ordinal, leap_r, day, month, year[14:0]};
    end
  end

  assign m_tvalid        = out_valid;
  assign m_tdata         = out_data;
  assign status.is_load  = act == ACT_LOAD;
  assign status.div_busy = div_busy;
  assign status.out_free = !out_valid || m_tready;

endmodule

// ===== hw/rtl/gcdu_ctrl.sv =====
module gcdu_ctrl
  import gcdu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_GDIV,
    S_GWAIT,
    S_VALIDATE,
    S_STEP,
    S_Y400,
    S_Y400_WAIT,
    S_TAKE400,
    S_Y100,
    S_Y100_WAIT,
    S_SUM1,
    S_SUM2,
    S_SUM3,
    S_SCALE,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  dp_op_t op_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (s_tvalid) state_next = S_DECODE;
      S_DECODE:    state_next = status.is_load ? S_GDIV : S_STEP;
      S_GDIV:      state_next = S_GWAIT;
      S_GWAIT:     if (!status.div_busy) state_next = S_VALIDATE;
      S_VALIDATE:  state_next = S_Y400;
      S_STEP:      state_next = S_Y400;
      S_Y400:      state_next = S_Y400_WAIT;
      S_Y400_WAIT: if (!status.div_busy) state_next = S_TAKE400;
      S_TAKE400:   state_next = S_Y100;
      S_Y100:      state_next = S_Y100_WAIT;
      S_Y100_WAIT: if (!status.div_busy) state_next = S_SUM1;
      S_SUM1:      state_next = S_SUM2;
      S_SUM2:      state_next = S_SUM3;
      S_SUM3:      state_next = S_SCALE;
      S_SCALE:     state_next = S_EMIT;
      S_EMIT:      if (status.out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    case (state_next)
      S_IDLE:     op_next = OP_IDLE;
      S_GDIV:     op_next = OP_DIV_GIVEN;
      S_VALIDATE: op_next = OP_VALIDATE;
      S_STEP:     op_next = OP_STEP;
      S_Y400:     op_next = OP_DIV_Y400;
      S_TAKE400:  op_next = OP_TAKE_Q400;
      S_Y100:     op_next = OP_DIV_Y100;
      S_SUM1:     op_next = OP_SUM_YEARS;
      S_SUM2:     op_next = OP_SUM_CENT;
      S_SUM3:     op_next = OP_SUM_REST;
      S_SCALE:    op_next = OP_SCALE;
      S_EMIT:     op_next = OP_EMIT;
      default:    op_next = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cmd.op   <= OP_IDLE;
      s_tready <= 1'b1;
    end else begin
      state    <= state_next;
      cmd.op   <= op_next;
      s_tready <= state_next == S_IDLE;
    end
  end

endmodule

// ===== hw/rtl/gregorian_calendar_date_unit.sv =====
// Gregorian calendar date unit.
// The block holds one proleptic Gregorian date, 1970-01-01 after reset.
// Commands enter on the s_ stream: s_tuser carries the action (load, next
// day, previous day, compare) and s_tdata the given year, month and day.
// Each accepted item yields exactly one result item on the m_ stream with
// the stored date, leap flag, day of year, seconds since 1970-01-01, the
// compare order and a status.
// One item is in work at a time; s_tready is high only while idle.
// A step or compare makes two passes through the shared divider, by 400 and
// 100, and a load three; the states SUM1, SUM2, SUM3 and SCALE then sum the
// day count and scale it to seconds. s_tready returns in the same cycle as
// m_tvalid rises, so a new item is taken only once the last one is through.
// A finished result sits in the output register; the next item may be
// accepted and worked on meanwhile, and it waits at its last step while
// m_tready stays low. Reset is synchronous, clears both streams and
// returns the stored date to 1970-01-01.
`include "gregorian_calendar_date_unit_defines.svh"

module gregorian_calendar_date_unit
  import gcdu_pkg::*;
#(
  parameter int MIN_YEAR = -9999,
  parameter int MAX_YEAR = 9999
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // given_year[14:0], given_month[18:15], given_day[23:19]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // action[1:0]
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // cur_year[14:0], cur_month[18:15], cur_day[23:19], leap[24],
  // ordinal_day[33:25], epoch_seconds[73:34], order[75:74], status[77:76]
  output logic [OUT_DATA_W-1:0] m_tdata
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [4:0] out_day;
  logic [3:0] out_month;
  logic [1:0] out_order;
  logic [1:0] out_status;
  logic       out_date_ok;

  gcdu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  gcdu_datapath #(
    .MIN_YEAR (MIN_YEAR),
    .MAX_YEAR (MAX_YEAR)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .status   (status)
  );

  assign out_day     = m_tdata[23:19];
  assign out_month   = m_tdata[18:15];
  assign out_order   = m_tdata[75:74];
  assign out_status  = m_tdata[77:76];
  assign out_date_ok = (out_day != 5'd0) && (out_month != 4'd0) && (out_month <= 4'd12);

  `GCDU_ASSERT_NXT(a_ready_drops, clk, rst, s_tvalid && s_tready, !s_tready)
  `GCDU_ASSERT_IMP(a_out_date_valid, clk, rst, m_tvalid, out_date_ok)
  `GCDU_ASSERT_IMP(a_order_ok_only, clk, rst, m_tvalid && (out_order != ORD_EQUAL), out_status == ST_OK)

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import gcdu_pkg::*;

  localparam int MIN_YEAR       = -9999;
  localparam int MAX_YEAR       = 9999;
  localparam int PHASE_ITEMS    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 200;

  // Field layout of m_tdata[77:0], most significant field first.
  typedef struct packed {
    status_t     st;
    logic [1:0]  ord;
    logic [39:0] secs;
    logic [8:0]  yday;
    logic        leap;
    logic [4:0]  mday;
    logic [3:0]  mon;
    logic [14:0] yr;
  } date_result_t;

  typedef struct {
    action_t      act;
    int           yr;
    int           mon;
    int           mday;
    bit           typed;
    date_result_t want_r;
  } cmd_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [1:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  date_result_t expected_dates[$];
  cmd_row_t     directed_rows[$];

  int cal_year  = 1970;
  int cal_month = 1;
  int cal_day   = 1;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int quiet_cycles  = 0;
  int mismatches    = 0;
  int n_loads       = 0;
  int n_steps       = 0;
  int n_compares    = 0;
  int n_rejected    = 0;
  int n_refused     = 0;
  int n_checked     = 0;

  gregorian_calendar_date_unit #(
    .MIN_YEAR(MIN_YEAR),
    .MAX_YEAR(MAX_YEAR)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic bit leap_year_of(int y);
    return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
  endfunction

  function automatic int month_days(int m, int y);
    case (m)
      2:              return leap_year_of(y) ? 29 : 28;
      4, 6, 9, 11:    return 30;
      1, 3, 5, 7, 8,
      10, 12:         return 31;
      default:        return 0;
    endcase
  endfunction

  // Days from 1970-01-01, counting eras of 400 years from March 1 of year 0.
  function automatic longint epoch_day_count(int y, int m, int d);
    longint yy;
    longint era;
    longint yoe;
    longint mp;
    longint doy;
    longint doe;
    yy  = y - ((m <= 2) ? 1 : 0);
    era = ((yy >= 0) ? yy : yy - 399) / 400;
    yoe = yy - era * 400;
    mp  = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  function automatic date_result_t want(int y, int m, int d, bit lp, int yday, longint secs,
                                        logic [1:0] ord, status_t st);
    date_result_t r;
    r.yr   = 15'(y);
    r.mon  = 4'(m);
    r.mday = 5'(d);
    r.leap = lp;
    r.yday = 9'(yday);
    r.secs = secs[39:0];
    r.ord  = ord;
    r.st   = st;
    return r;
  endfunction

  function automatic cmd_row_t mk_row(action_t act, int y, int m, int d, bit typed = 1'b0,
                                      date_result_t want_r = '0);
    cmd_row_t row;
    row.act    = act;
    row.yr     = y;
    row.mon    = m;
    row.mday   = d;
    row.typed  = typed;
    row.want_r = want_r;
    return row;
  endfunction

  function automatic date_result_t predict_date(action_t act, logic [14:0] gy_raw,
                                                logic [3:0] gm_raw, logic [4:0] gd_raw);
    int           gy;
    int           gm;
    int           gd;
    int           yday;
    longint       secs;
    logic [1:0]   ord;
    status_t      st;
    date_result_t r;
    gy  = $signed(gy_raw);
    gm  = gm_raw;
    gd  = gd_raw;
    ord = ORD_EQUAL;
    st  = ST_OK;
    case (act)
      ACT_LOAD: begin
        if (gm < 1 || gm > 12 || gy < MIN_YEAR || gy > MAX_YEAR || gd == 0 ||
            gd > month_days(gm, gy)) begin
          st = ST_INVALID;
        end else begin
          cal_year  = gy;
          cal_month = gm;
          cal_day   = gd;
        end
      end
      ACT_NEXT: begin
        if (cal_day == month_days(cal_month, cal_year)) begin
          if (cal_month == 12) begin
            if (cal_year >= MAX_YEAR) begin
              st = ST_BOUND;
            end else begin
              cal_year  = cal_year + 1;
              cal_month = 1;
              cal_day   = 1;
            end
          end else begin
            cal_month = cal_month + 1;
            cal_day   = 1;
          end
        end else begin
          cal_day = cal_day + 1;
        end
      end
      ACT_PREV: begin
        if (cal_day > 1) begin
          cal_day = cal_day - 1;
        end else if (cal_month == 1) begin
          if (cal_year <= MIN_YEAR) begin
            st = ST_BOUND;
          end else begin
            cal_year  = cal_year - 1;
            cal_month = 12;
            cal_day   = 31;
          end
        end else begin
          cal_month = cal_month - 1;
          cal_day   = month_days(cal_month, cal_year);
        end
      end
      default: begin
        if (cal_year != gy) begin
          ord = (cal_year > gy) ? ORD_LATER : ORD_EARLIER;
        end else if (cal_month != gm) begin
          ord = (cal_month > gm) ? ORD_LATER : ORD_EARLIER;
        end else if (cal_day != gd) begin
          ord = (cal_day > gd) ? ORD_LATER : ORD_EARLIER;
        end
      end
    endcase
    yday = cal_day;
    for (int k = 1; k < cal_month; k++) begin
      yday += month_days(k, cal_year);
    end
    secs = epoch_day_count(cal_year, cal_month, cal_day) * 86400;
    r = want(cal_year, cal_month, cal_day, leap_year_of(cal_year), yday, secs, ord, st);
    return r;
  endfunction

  task automatic send_cmd(action_t act, logic [14:0] y, logic [3:0] m, logic [4:0] d,
                          bit typed = 1'b0, date_result_t want_r = '0);
    date_result_t r;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {d, m, y};
    do @(posedge clk); while (!s_tready);
    r = predict_date(act, y, m, d);
    expected_dates.push_back(typed ? want_r : r);
    case (act)
      ACT_LOAD:    n_loads++;
      ACT_COMPARE: n_compares++;
      default:     n_steps++;
    endcase
    if (r.st == ST_INVALID) n_rejected++;
    if (r.st == ST_BOUND) n_refused++;
  endtask

  function automatic int pick_year();
    case ($urandom_range(4))
      0:       return int'($urandom_range(2100, 1900));
      1:       return MAX_YEAR - int'($urandom_range(2));
      2:       return MIN_YEAR + int'($urandom_range(2));
      3:       return (int'($urandom_range(48)) - 24) * 400 + 100 * int'($urandom_range(3));
      default: return MIN_YEAR + int'($urandom_range(MAX_YEAR - MIN_YEAR));
    endcase
  endfunction

  // Mostly a valid load followed by a few steps and maybe a nearby compare;
  // the rest is a single command with every field random.
  task automatic random_burst(output int sent);
    int y;
    int m;
    int d;
    int len;
    int steps;
    sent = 0;
    if ($urandom_range(99) < 25) begin
      send_cmd(action_t'($urandom_range(3)), 15'($urandom), 4'($urandom), 5'($urandom));
      sent = 1;
    end else begin
      y = pick_year();
      m = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 12 : 1) : int'($urandom_range(12, 1));
      len = month_days(m, y);
      case ($urandom_range(2))
        0:       d = int'($urandom_range(len, 1));
        1:       d = len - int'($urandom_range(1));
        default: d = 1 + int'($urandom_range(1));
      endcase
      send_cmd(ACT_LOAD, 15'(y), 4'(m), 5'(d));
      steps = $urandom_range(6, 1);
      for (int k = 0; k < steps; k++) begin
        send_cmd(action_t'($urandom_range(1) ? ACT_NEXT : ACT_PREV), 15'($urandom),
                 4'($urandom), 5'($urandom));
      end
      sent = 1 + steps;
      if ($urandom_range(1)) begin
        y = cal_year;
        m = cal_month;
        d = cal_day;
        case ($urandom_range(3))
          0:       y += $urandom_range(1) ? 1 : -1;
          1:       m += $urandom_range(1) ? 1 : -1;
          2:       d += $urandom_range(1) ? 1 : -1;
          default: ;
        endcase
        send_cmd(ACT_COMPARE, 15'(y), 4'(m), 5'(d));
        sent++;
      end
    end
  endtask

  task automatic compare_field(string name, longint want_v, longint got_v);
    if (want_v != got_v) begin
      $display("%0t tb: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  task automatic check_result(date_result_t got);
    date_result_t exp_r;
    if (expected_dates.size() == 0) begin
      $display("%0t tb: result item with nothing expected, expected none, got %p", $time, got);
      mismatches++;
    end else begin
      exp_r = expected_dates.pop_front();
      n_checked++;
      compare_field("cur_year", exp_r.yr, got.yr);
      compare_field("cur_month", exp_r.mon, got.mon);
      compare_field("cur_day", exp_r.mday, got.mday);
      compare_field("leap", exp_r.leap, got.leap);
      compare_field("ordinal_day", exp_r.yday, got.yday);
      compare_field("epoch_seconds", exp_r.secs, got.secs);
      compare_field("order", exp_r.ord, got.ord);
      compare_field("status", exp_r.st, got.st);
    end
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (m_tvalid && m_tready) check_result(date_result_t'(m_tdata[77:0]));
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t tb: no item moved for %0d cycles", $time, quiet_cycles);
        $display("tb: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int sent;
    int items;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_rows.push_back(mk_row(ACT_COMPARE, 1970, 1, 1, 1,
                                   want(1970, 1, 1, 0, 1, 0, ORD_EQUAL, ST_OK)));
    directed_rows.push_back(mk_row(ACT_NEXT, 0, 0, 0, 1,
                                   want(1970, 1, 2, 0, 2, 86400, ORD_EQUAL, ST_OK)));
    directed_rows.push_back(mk_row(ACT_PREV, 0, 0, 0, 1,
                                   want(1970, 1, 1, 0, 1, 0, ORD_EQUAL, ST_OK)));
    directed_rows.push_back(mk_row(ACT_PREV, 0, 0, 0, 1,
                                   want(1969, 12, 31, 0, 365, -86400, ORD_EQUAL, ST_OK)));
    directed_rows.push_back(mk_row(ACT_LOAD, 2000, 13, 1, 1,
                                   want(1969, 12, 31, 0, 365, -86400, ORD_EQUAL, ST_INVALID)));
    directed_rows.push_back(mk_row(ACT_LOAD, 2000, 0, 15));
    directed_rows.push_back(mk_row(ACT_LOAD, 2000, 1, 0));
    directed_rows.push_back(mk_row(ACT_LOAD, 2001, 2, 29));
    directed_rows.push_back(mk_row(ACT_LOAD, 2000, 2, 29));
    directed_rows.push_back(mk_row(ACT_NEXT, 0, 0, 0));
    directed_rows.push_back(mk_row(ACT_LOAD, 1900, 2, 28));
    directed_rows.push_back(mk_row(ACT_NEXT, 0, 0, 0));
    directed_rows.push_back(mk_row(ACT_LOAD, 2024, 12, 31));
    directed_rows.push_back(mk_row(ACT_NEXT, 0, 0, 0));
    directed_rows.push_back(mk_row(ACT_LOAD, 10000, 1, 1));
    directed_rows.push_back(mk_row(ACT_LOAD, -16384, 1, 1));
    directed_rows.push_back(mk_row(ACT_LOAD, 9999, 12, 31, 1,
                                   want(9999, 12, 31, 0, 365, 64'sd253402214400,
                                        ORD_EQUAL, ST_OK)));
    directed_rows.push_back(mk_row(ACT_NEXT, 0, 0, 0, 1,
                                   want(9999, 12, 31, 0, 365, 64'sd253402214400,
                                        ORD_EQUAL, ST_BOUND)));
    directed_rows.push_back(mk_row(ACT_COMPARE, -16384, 15, 31));
    directed_rows.push_back(mk_row(ACT_LOAD, -9999, 1, 1, 1,
                                   want(-9999, 1, 1, 0, 1, -64'sd377705116800,
                                        ORD_EQUAL, ST_OK)));
    directed_rows.push_back(mk_row(ACT_PREV, 0, 0, 0, 1,
                                   want(-9999, 1, 1, 0, 1, -64'sd377705116800,
                                        ORD_EQUAL, ST_BOUND)));
    directed_rows.push_back(mk_row(ACT_COMPARE, -9999, 1, 2));
    directed_rows.push_back(mk_row(ACT_LOAD, 16383, 4, 31));
    directed_rows.push_back(mk_row(ACT_COMPARE, 16383, 15, 31));
    directed_rows.push_back(mk_row(ACT_LOAD, 2023, 4, 31));

    foreach (directed_rows[i]) begin
      send_cmd(directed_rows[i].act, 15'(directed_rows[i].yr), 4'(directed_rows[i].mon),
               5'(directed_rows[i].mday), directed_rows[i].typed, directed_rows[i].want_r);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 61; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 61; end
        default: begin send_idle_pct = 28; stall_pct = 28; end
      endcase
      items = 0;
      while (items < PHASE_ITEMS) begin
        random_burst(sent);
        items += sent;
      end
    end

    s_tvalid <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d commands: %0d loads, %0d day steps, %0d compares, %0d results checked",
             n_loads + n_steps + n_compares, n_loads, n_steps, n_compares, n_checked);
    $display("tb: %0d invalid loads rejected, %0d steps refused at the year bounds",
             n_rejected, n_refused);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
